### src/cdt_pkg.sv
// shared types, constants and helper functions for the countdown timer
package cdt_pkg;

  localparam int unsigned CFG_W = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [0:0] REG_TICK_PERIOD = 1'b0;
  localparam logic [0:0] REG_BLINK_POINT = 1'b1;

  localparam logic [CFG_W-1:0] TICK_PERIOD_RST = 8'd113;
  localparam logic [CFG_W-1:0] BLINK_POINT_RST = 8'd55;

  localparam logic [5:0] MIN_MAX = 6'd59;
  localparam logic [5:0] SEC_MAX = 6'd59;
  localparam logic [4:0] HOUR_MAX = 5'd23;

  localparam logic [DIGIT_W-1:0] DIGIT_BLANK = 4'd10;

  localparam logic [1:0] CODE_IDLE = 2'd0;
  localparam logic [1:0] CODE_SET_MIN = 2'd1;
  localparam logic [1:0] CODE_SET_HOUR = 2'd2;
  localparam logic [1:0] CODE_RUN = 2'd3;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_SET_MIN  = 4'b0010,
    MODE_SET_HOUR = 4'b0100,
    MODE_RUN      = 4'b1000
  } mode_t;

  typedef struct packed {
    logic tick;
    logic key_down;
    logic enc_a;
    logic enc_b;
  } cdt_in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit_hour_tens;
    logic [DIGIT_W-1:0] digit_hour_ones;
    logic [DIGIT_W-1:0] digit_min_tens;
    logic [DIGIT_W-1:0] digit_min_ones;
    logic               colon_on;
    logic               buzzer_on;
    logic               led_on;
    logic [1:0]         mode_now;
  } cdt_out_t;

  // tens digit of a value below 64
  function automatic logic [DIGIT_W-1:0] dec_tens(input logic [5:0] v);
    logic [DIGIT_W-1:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [DIGIT_W-1:0] dec_ones(input logic [5:0] v);
    logic [6:0] tens_x10;
    logic [6:0] diff;
    tens_x10 = 7'(dec_tens(v)) * 7'd10;
    diff = {1'b0, v} - tens_x10;
    return diff[DIGIT_W-1:0];
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_SET_MIN:  c = CODE_SET_MIN;
      MODE_SET_HOUR: c = CODE_SET_HOUR;
      MODE_RUN:      c = CODE_RUN;
      default:       c = CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

### src/cdt_if.sv
// valid/ready channel interfaces for sample input and display result
interface cdt_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic key_down;
  logic enc_a;
  logic enc_b;

  modport source(output valid, tick, key_down, enc_a, enc_b, input ready);
  modport sink(input valid, tick, key_down, enc_a, enc_b, output ready);
endinterface

interface cdt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_hour_tens;
  logic [3:0] digit_hour_ones;
  logic [3:0] digit_min_tens;
  logic [3:0] digit_min_ones;
  logic       colon_on;
  logic       buzzer_on;
  logic       led_on;
  logic [1:0] mode_now;

  modport source(output valid, digit_hour_tens, digit_hour_ones, digit_min_tens,
                 digit_min_ones, colon_on, buzzer_on, led_on, mode_now, input ready);
  modport sink(input valid, digit_hour_tens, digit_hour_ones, digit_min_tens,
               digit_min_ones, colon_on, buzzer_on, led_on, mode_now, output ready);
  modport monitor(input valid, ready, digit_hour_tens, digit_hour_ones, digit_min_tens,
                  digit_min_ones, colon_on, buzzer_on, led_on, mode_now);
endinterface

### src/cdt_in_reg.sv
// input register stage for samples
module cdt_in_reg import cdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cdt_in_if.sink    in_ch,
  input  logic      load_ok,
  output logic      valid,
  output cdt_in_t   sample
);

  assign in_ch.ready = !valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      sample <= '{tick: in_ch.tick, key_down: in_ch.key_down,
                  enc_a: in_ch.enc_a, enc_b: in_ch.enc_b};
    end
  end

endmodule

### src/cdt_engine.sv
// timer state, config registers and per-sample update logic
module cdt_engine import cdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             fire,
  input  cdt_in_t          sample,
  output cdt_out_t         result
);

  logic [CFG_W-1:0] tick_period;
  logic [CFG_W-1:0] blink_point;

  mode_t      mode;
  logic [7:0] prescale_count;
  logic       blink_phase;
  logic       second_pending;
  logic [4:0] hours_left;
  logic [5:0] minutes_left;
  logic [5:0] seconds_left;
  logic [5:0] set_minutes;
  logic [4:0] set_hours;
  logic       prev_enc_a;
  logic       expired;
  logic [15:0] elapsed_seconds;

  mode_t      mode_next;
  logic [7:0] prescale_count_next;
  logic       blink_phase_next;
  logic       second_pending_next;
  logic [4:0] hours_left_next;
  logic [5:0] minutes_left_next;
  logic [5:0] seconds_left_next;
  logic [5:0] set_minutes_next;
  logic [4:0] set_hours_next;
  logic       prev_enc_a_next;
  logic       expired_next;
  logic [15:0] elapsed_seconds_next;

  logic [7:0] pc_inc;
  logic       clear_all;
  logic       enc_fall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_PERIOD_RST;
      blink_point <= BLINK_POINT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICK_PERIOD: tick_period <= cfg_data;
        REG_BLINK_POINT: blink_point <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next            = mode;
    prescale_count_next  = prescale_count;
    blink_phase_next     = blink_phase;
    second_pending_next  = second_pending;
    hours_left_next      = hours_left;
    minutes_left_next    = minutes_left;
    seconds_left_next    = seconds_left;
    set_minutes_next     = set_minutes;
    set_hours_next       = set_hours;
    prev_enc_a_next      = prev_enc_a;
    expired_next         = expired;
    elapsed_seconds_next = elapsed_seconds;
    clear_all            = 1'b0;
    pc_inc               = prescale_count + 8'd1;
    enc_fall             = prev_enc_a && !sample.enc_a;

    result = '{digit_hour_tens: 4'd0, digit_hour_ones: 4'd0, digit_min_tens: 4'd0,
               digit_min_ones: 4'd0, colon_on: 1'b0, buzzer_on: 1'b0, led_on: 1'b1,
               mode_now: CODE_IDLE};

    // prescaler
    if (sample.tick) begin
      prescale_count_next = pc_inc;
      blink_phase_next = blink_phase ^ (pc_inc == blink_point) ^ (pc_inc == tick_period);
      if (pc_inc == tick_period) begin
        prescale_count_next = 8'd0;
        second_pending_next = 1'b1;
      end
    end

    // key steps the mode; in run mode it clears the timer instead
    if (sample.key_down) begin
      case (mode)
        MODE_IDLE:     mode_next = MODE_SET_MIN;
        MODE_SET_MIN:  mode_next = MODE_SET_HOUR;
        MODE_SET_HOUR: mode_next = MODE_RUN;
        MODE_RUN:      clear_all = 1'b1;
        default:       mode_next = MODE_SET_MIN;
      endcase
    end

    if (!clear_all) begin
      case (mode_next)
        MODE_SET_MIN: begin
          result.digit_hour_tens = dec_tens({1'b0, hours_left});
          result.digit_hour_ones = dec_ones({1'b0, hours_left});
          result.digit_min_tens  = blink_phase_next ? DIGIT_BLANK : dec_tens(minutes_left);
          result.digit_min_ones  = blink_phase_next ? DIGIT_BLANK : dec_ones(minutes_left);
          result.colon_on = 1'b1;
          prev_enc_a_next = sample.enc_a;
          if (enc_fall) begin
            if (sample.enc_b) begin
              set_minutes_next = (set_minutes >= MIN_MAX) ? 6'd0 : set_minutes + 6'd1;
            end else begin
              set_minutes_next = (set_minutes == 6'd0 || set_minutes > MIN_MAX) ?
                                 MIN_MAX : set_minutes - 6'd1;
            end
            minutes_left_next = set_minutes_next;
          end
        end
        MODE_SET_HOUR: begin
          result.digit_hour_tens = blink_phase_next ? dec_tens({1'b0, hours_left}) : DIGIT_BLANK;
          result.digit_hour_ones = blink_phase_next ? dec_ones({1'b0, hours_left}) : DIGIT_BLANK;
          result.digit_min_tens  = dec_tens(minutes_left);
          result.digit_min_ones  = dec_ones(minutes_left);
          result.colon_on = 1'b1;
          prev_enc_a_next = sample.enc_a;
          if (enc_fall) begin
            if (sample.enc_b) begin
              set_hours_next = (set_hours >= HOUR_MAX) ? 5'd0 : set_hours + 5'd1;
            end else begin
              set_hours_next = (set_hours == 5'd0 || set_hours > HOUR_MAX) ?
                               HOUR_MAX : set_hours - 5'd1;
            end
            hours_left_next = set_hours_next;
          end
        end
        MODE_RUN: begin
          if (second_pending_next) begin
            second_pending_next = 1'b0;
            if (seconds_left != 6'd0) begin
              seconds_left_next = seconds_left - 6'd1;
              elapsed_seconds_next = elapsed_seconds + 16'd1;
            end else if (minutes_left != 6'd0) begin
              minutes_left_next = minutes_left - 6'd1;
              seconds_left_next = SEC_MAX;
            end else if (hours_left != 5'd0) begin
              hours_left_next = hours_left - 5'd1;
              minutes_left_next = MIN_MAX;
              seconds_left_next = SEC_MAX;
            end else begin
              expired_next = 1'b1;
            end
          end
          if (expired_next) begin
            if (!blink_phase_next) begin
              result.digit_hour_tens = DIGIT_BLANK;
              result.digit_hour_ones = DIGIT_BLANK;
              result.digit_min_tens  = DIGIT_BLANK;
              result.digit_min_ones  = DIGIT_BLANK;
              result.buzzer_on = (elapsed_seconds_next != 16'd0);
            end else begin
              result.colon_on = 1'b1;
            end
          end else begin
            result.digit_hour_tens = dec_tens({1'b0, hours_left_next});
            result.digit_hour_ones = dec_ones({1'b0, hours_left_next});
            result.digit_min_tens  = dec_tens(minutes_left_next);
            result.digit_min_ones  = dec_ones(minutes_left_next);
            result.colon_on = blink_phase_next;
            result.led_on = 1'b0;
          end
        end
        default: ;
      endcase
      result.mode_now = mode_code(mode_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && clear_all)) begin
      mode            <= MODE_IDLE;
      prescale_count  <= 8'd0;
      blink_phase     <= 1'b0;
      second_pending  <= 1'b0;
      hours_left      <= 5'd0;
      minutes_left    <= 6'd0;
      seconds_left    <= 6'd0;
      set_minutes     <= 6'd0;
      set_hours       <= 5'd0;
      prev_enc_a      <= 1'b0;
      expired         <= 1'b0;
      elapsed_seconds <= 16'd0;
    end else if (fire) begin
      mode            <= mode_next;
      prescale_count  <= prescale_count_next;
      blink_phase     <= blink_phase_next;
      second_pending  <= second_pending_next;
      hours_left      <= hours_left_next;
      minutes_left    <= minutes_left_next;
      seconds_left    <= seconds_left_next;
      set_minutes     <= set_minutes_next;
      set_hours       <= set_hours_next;
      prev_enc_a      <= prev_enc_a_next;
      expired         <= expired_next;
      elapsed_seconds <= elapsed_seconds_next;
    end
  end

endmodule

### src/cdt_out_reg.sv
// result register driving the output channel
module cdt_out_reg import cdt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  cdt_out_t  result,
  output logic      load_ok,
  cdt_out_if.source out_ch
);

  cdt_out_t held;

  assign load_ok = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_ok) begin
      out_ch.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      held <= result;
    end
  end

  assign out_ch.digit_hour_tens = held.digit_hour_tens;
  assign out_ch.digit_hour_ones = held.digit_hour_ones;
  assign out_ch.digit_min_tens  = held.digit_min_tens;
  assign out_ch.digit_min_ones  = held.digit_min_ones;
  assign out_ch.colon_on        = held.colon_on;
  assign out_ch.buzzer_on       = held.buzzer_on;
  assign out_ch.led_on          = held.led_on;
  assign out_ch.mode_now        = held.mode_now;

endmodule

### src/countdown_timer_encoder_set_unit.sv
// top level: hh:mm countdown timer set by rotary encoder and key
// a sample transfer is captured in the input register, and its result is
// registered in the result register before it can transfer out
// throughput: one sample per cycle while the result channel is not stalled,
// set by the single-pass state update between input and result registers
// reset (synchronous, rst high) clears all timer state and both stage valids,
// and loads tick_period = 113 and blink_point = 55
module countdown_timer_encoder_set_unit import cdt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  cdt_in_if.sink           in_ch,
  cdt_out_if.source        out_ch
);

  logic     s1_valid;
  cdt_in_t  s1_sample;
  logic     load_ok;
  cdt_out_t result;

  cdt_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .load_ok (load_ok),
    .valid   (s1_valid),
    .sample  (s1_sample)
  );

  cdt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (s1_valid && load_ok),
    .sample    (s1_sample),
    .result    (result)
  );

  cdt_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .result   (result),
    .load_ok  (load_ok),
    .out_ch   (out_ch)
  );

endmodule

### src/cdt_checker.sv
// port-level checks on the result channel, bound to the top level
module cdt_checker import cdt_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DIGIT_W-1:0] digit_hour_tens,
  input logic [DIGIT_W-1:0] digit_hour_ones,
  input logic [DIGIT_W-1:0] digit_min_tens,
  input logic [DIGIT_W-1:0] digit_min_ones,
  input logic               colon_on,
  input logic               buzzer_on,
  input logic               led_on,
  input logic [1:0]         mode_now
);

  // idle and cleared samples show 00:00 with only the led lit
  a_idle_display: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode_now == CODE_IDLE) |->
      (led_on && !colon_on && !buzzer_on &&
       digit_hour_tens == 4'd0 && digit_hour_ones == 4'd0 &&
       digit_min_tens == 4'd0 && digit_min_ones == 4'd0))
    else $error("idle result shows wrong display");

  // buzzer sounds only in run mode with a blank display
  a_buzzer_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buzzer_on) |->
      (mode_now == CODE_RUN && !colon_on && led_on &&
       digit_hour_tens == DIGIT_BLANK && digit_min_ones == DIGIT_BLANK))
    else $error("buzzer on outside expired run display");

  // set modes keep the colon and led on, buzzer off
  a_set_display: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mode_now == CODE_SET_MIN || mode_now == CODE_SET_HOUR)) |->
      (colon_on && led_on && !buzzer_on))
    else $error("set mode display flags wrong");

  // a stalled result transfer holds its valid, mode, minute ones digit, led and buzzer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(mode_now) && $stable(digit_min_ones) &&
       $stable(led_on) && $stable(buzzer_on)))
    else $error("stalled result changed");

endmodule

bind countdown_timer_encoder_set_unit cdt_checker u_cdt_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .digit_hour_tens (out_ch.digit_hour_tens),
  .digit_hour_ones (out_ch.digit_hour_ones),
  .digit_min_tens  (out_ch.digit_min_tens),
  .digit_min_ones  (out_ch.digit_min_ones),
  .colon_on        (out_ch.colon_on),
  .buzzer_on       (out_ch.buzzer_on),
  .led_on          (out_ch.led_on),
  .mode_now        (out_ch.mode_now)
);

### tb/sv/tb_countdown_timer_encoder_set_unit.sv
// self-checking bench for the countdown timer unit: predicts every display transfer and compares
module tb_countdown_timer_encoder_set_unit;
  import cdt_pkg::*;

  localparam int LATENCY = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SET_MIN  = 3'd1,
    ST_SET_HOUR = 3'd2,
    ST_RUN      = 3'd3,
    ST_CLEAR    = 3'd4
  } timer_step_t;

  class display_scoreboard;
    logic [CFG_W-1:0] tick_period;
    logic [CFG_W-1:0] blink_point;
    timer_step_t      mode_reg;
    logic [7:0]       prescale;
    logic             blink;
    logic             sec_pending;
    logic [4:0]       hours_left;
    logic [5:0]       minutes_left;
    logic [5:0]       seconds_left;
    logic [5:0]       set_minutes;
    logic [4:0]       set_hours;
    logic             prev_a;
    logic             expired;
    logic [15:0]      elapsed;
    cdt_out_t         display_q[$];
    int samples, checked, fails, expiries, buzzes, hour_borrows;

    function new();
      tick_period = TICK_PERIOD_RST;
      blink_point = BLINK_POINT_RST;
      clear_timer();
    endfunction

    function void clear_timer();
      mode_reg = ST_IDLE;
      prescale = '0;
      blink = 1'b0;
      sec_pending = 1'b0;
      hours_left = '0;
      minutes_left = '0;
      seconds_left = '0;
      set_minutes = '0;
      set_hours = '0;
      prev_a = 1'b0;
      expired = 1'b0;
      elapsed = '0;
    endfunction

    function void load_register(logic [0:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_TICK_PERIOD) tick_period = val;
      else blink_point = val;
    endfunction

    function int pending();
      return display_q.size();
    endfunction

    function cdt_out_t face(logic [4:0] hh, logic [5:0] mm);
      cdt_out_t o;
      o = '0;
      o.digit_hour_tens = DIGIT_W'(hh / 5'd10);
      o.digit_hour_ones = DIGIT_W'(hh % 5'd10);
      o.digit_min_tens = DIGIT_W'(mm / 6'd10);
      o.digit_min_ones = DIGIT_W'(mm % 6'd10);
      o.led_on = 1'b1;
      return o;
    endfunction

    function void note_sample(cdt_in_t s);
      cdt_out_t o;
      logic fall;
      o = face(5'd0, 6'd0);
      samples++;
      if (s.tick) begin
        prescale = prescale + 8'd1;
        if (prescale == blink_point) blink = !blink;
        if (prescale == tick_period) begin
          prescale = '0;
          blink = !blink;
          sec_pending = 1'b1;
        end
      end
      if (s.key_down) mode_reg = timer_step_t'(mode_reg + 3'd1);
      fall = 1'b0;
      if (mode_reg == ST_SET_MIN || mode_reg == ST_SET_HOUR) begin
        fall = prev_a && !s.enc_a;
        prev_a = s.enc_a;
      end
      case (mode_reg)
        ST_SET_MIN: begin
          o = face(hours_left, minutes_left);
          o.colon_on = 1'b1;
          if (blink) begin
            o.digit_min_tens = DIGIT_BLANK;
            o.digit_min_ones = DIGIT_BLANK;
          end
          if (fall) begin
            if (s.enc_b) set_minutes = (set_minutes >= MIN_MAX) ? 6'd0 : set_minutes + 6'd1;
            else set_minutes = (set_minutes == 6'd0 || set_minutes > MIN_MAX) ?
                               MIN_MAX : set_minutes - 6'd1;
            minutes_left = set_minutes;
          end
        end
        ST_SET_HOUR: begin
          o = face(hours_left, minutes_left);
          o.colon_on = 1'b1;
          if (!blink) begin
            o.digit_hour_tens = DIGIT_BLANK;
            o.digit_hour_ones = DIGIT_BLANK;
          end
          if (fall) begin
            if (s.enc_b) set_hours = (set_hours >= HOUR_MAX) ? 5'd0 : set_hours + 5'd1;
            else set_hours = (set_hours == 5'd0 || set_hours > HOUR_MAX) ?
                             HOUR_MAX : set_hours - 5'd1;
            hours_left = set_hours;
          end
        end
        ST_RUN: begin
          if (sec_pending) begin
            sec_pending = 1'b0;
            if (seconds_left != 6'd0) begin
              seconds_left = seconds_left - 6'd1;
              elapsed = elapsed + 16'd1;
            end else if (minutes_left != 6'd0) begin
              minutes_left = minutes_left - 6'd1;
              seconds_left = SEC_MAX;
            end else if (hours_left != 5'd0) begin
              hours_left = hours_left - 5'd1;
              minutes_left = MIN_MAX;
              seconds_left = SEC_MAX;
              hour_borrows++;
            end else begin
              if (!expired) expiries++;
              expired = 1'b1;
            end
          end
          if (expired) begin
            if (!blink) begin
              o.digit_hour_tens = DIGIT_BLANK;
              o.digit_hour_ones = DIGIT_BLANK;
              o.digit_min_tens = DIGIT_BLANK;
              o.digit_min_ones = DIGIT_BLANK;
              o.buzzer_on = (elapsed != 16'd0);
            end else begin
              o.colon_on = 1'b1;
            end
          end else begin
            o = face(hours_left, minutes_left);
            o.colon_on = blink;
            o.led_on = 1'b0;
          end
          if (o.buzzer_on) buzzes++;
        end
        ST_CLEAR: clear_timer();
        default: ;
      endcase
      o.mode_now = mode_reg[1:0];
      display_q.push_back(o);
    endfunction

    function void check_display(cdt_out_t got);
      cdt_out_t want;
      logic bad;
      checked++;
      if (display_q.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX) $display("display transfer %0d with nothing expected", checked);
        return;
      end
      want = display_q.pop_front();
      bad = (got.digit_hour_tens !== want.digit_hour_tens) ||
            (got.digit_hour_ones !== want.digit_hour_ones) ||
            (got.digit_min_tens !== want.digit_min_tens) ||
            (got.digit_min_ones !== want.digit_min_ones) ||
            (got.colon_on !== want.colon_on) ||
            (got.buzzer_on !== want.buzzer_on) ||
            (got.led_on !== want.led_on) ||
            (got.mode_now !== want.mode_now);
      if (bad) begin
        fails++;
        if (fails <= REPORT_MAX) begin
          $display("display %0d mismatch: expected %0d %0d : %0d %0d colon %b buzzer %b led %b mode %0d",
                   checked, want.digit_hour_tens, want.digit_hour_ones, want.digit_min_tens,
                   want.digit_min_ones, want.colon_on, want.buzzer_on, want.led_on, want.mode_now);
          $display("  actual %0d %0d : %0d %0d colon %b buzzer %b led %b mode %0d",
                   got.digit_hour_tens, got.digit_hour_ones, got.digit_min_tens,
                   got.digit_min_ones, got.colon_on, got.buzzer_on, got.led_on, got.mode_now);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  cdt_in_if in_ch();
  cdt_out_if out_ch();

  display_scoreboard sb = new();

  int goal_min = 0;
  int goal_hour = 0;
  int settings_used = 0;
  int cycles = 0;
  bit src_steady = 1'b0;
  bit snk_steady = 1'b0;

  // tick key a b
  logic [3:0] opening [0:21] = '{
    4'b0000, 4'b1000, 4'b0100, 4'b0010, 4'b0000, 4'b0011, 4'b0001, 4'b1111,
    4'b0000, 4'b0011, 4'b0001, 4'b0011, 4'b0001, 4'b0100, 4'b1000, 4'b1010,
    4'b0100, 4'b0100, 4'b0100, 4'b1100, 4'b1000, 4'b0100
  };

  countdown_timer_encoder_set_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d displays still expected", cycles, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pause_len(bit steady);
    int r;
    r = $urandom_range(0, 9);
    if (steady || r < 5) return 0;
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  // walk the set value toward its goal by falling edges of phase a
  function automatic cdt_in_t steer(cdt_in_t s, int cur, int goal, int top);
    int ahead;
    ahead = (goal - cur + top + 1) % (top + 1);
    if (ahead == 0) begin
      s.enc_a = sb.prev_a;
      s.key_down = ($urandom_range(0, 99) < 30);
    end else if (sb.prev_a && $urandom_range(0, 99) < 70) begin
      s.enc_a = 1'b0;
      s.enc_b = (ahead <= (top + 1) / 2);
    end else begin
      s.enc_a = 1'b1;
    end
    return s;
  endfunction

  function automatic cdt_in_t pick_sample(int tick_pct, bit allow_clear);
    cdt_in_t s;
    int key_pct;
    s = cdt_in_t'(4'($urandom_range(0, 15)));
    if ($urandom_range(0, 99) >= 8) begin
      s.tick = ($urandom_range(0, 99) < tick_pct);
      s.key_down = 1'b0;
      case (sb.mode_reg)
        ST_SET_MIN:  s = steer(s, sb.set_minutes, goal_min, MIN_MAX);
        ST_SET_HOUR: s = steer(s, sb.set_hours, goal_hour, HOUR_MAX);
        ST_RUN: begin
          if (sb.expired) key_pct = 12;
          else if (sb.hours_left != 5'd0 || sb.minutes_left > 6'd2) key_pct = 6;
          else key_pct = 1;
          s.key_down = ($urandom_range(0, 99) < key_pct);
        end
        default: begin
          s.key_down = ($urandom_range(0, 99) < 40);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: goal_min = 0;
            4, 5, 6:    goal_min = 1;
            7, 8:       goal_min = 2;
            default:    goal_min = MIN_MAX;
          endcase
          if ($urandom_range(0, 9) < 8) goal_hour = 0;
          else goal_hour = $urandom_range(0, 1) ? 1 : HOUR_MAX;
        end
      endcase
    end
    if (!allow_clear && sb.mode_reg == ST_RUN) s.key_down = 1'b0;
    return s;
  endfunction

  task automatic send_sample(cdt_in_t s);
    int gap;
    if ($urandom_range(0, 31) == 0) src_steady = !src_steady;
    gap = pause_len(src_steady);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.tick, in_ch.key_down, in_ch.enc_a, in_ch.enc_b} <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_timing(logic [CFG_W-1:0] period, logic [CFG_W-1:0] point);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_TICK_PERIOD;
    cfg_data <= period;
    @(posedge clk);
    cfg_index <= REG_BLINK_POINT;
    cfg_data <= point;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.load_register(REG_TICK_PERIOD, period);
    sb.load_register(REG_BLINK_POINT, point);
    settings_used++;
  endtask

  task automatic run_phase(int n, int tick_pct, bit allow_clear, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      // with hold_mid set, the sender holds off at the halfway point until every display has come back
      if (hold_mid && i == n / 2) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
      send_sample(pick_sample(tick_pct, allow_clear));
    end
  endtask

  initial begin : display_sink
    cdt_out_t got;
    int stall;
    out_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 31) == 0) snk_steady = !snk_steady;
      stall = pause_len(snk_steady);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got = {out_ch.digit_hour_tens, out_ch.digit_hour_ones, out_ch.digit_min_tens,
             out_ch.digit_min_ones, out_ch.colon_on, out_ch.buzzer_on, out_ch.led_on,
             out_ch.mode_now};
      sb.check_display(got);
    end
  end

  initial begin : stimulus
    cfg_we = 1'b0;
    cfg_index = REG_TICK_PERIOD;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.tick = 1'b0;
    in_ch.key_down = 1'b0;
    in_ch.enc_a = 1'b0;
    in_ch.enc_b = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // equal blink point and period, one second per tick
    set_timing(8'd1, 8'd1);
    foreach (opening[i]) send_sample(cdt_in_t'(opening[i]));
    run_phase(70, 80, 1'b1, 1'b1);

    set_timing(8'd2, 8'd1);
    run_phase(70, 85, 1'b1, 1'b0);

    set_timing(8'd255, 8'd255);
    run_phase(20, 90, 1'b1, 1'b0);

    // zero period wraps through 256 ticks, no clearing so the prescaler gets there
    set_timing(8'd0, 8'd255);
    run_phase(270, 97, 1'b0, 1'b0);

    set_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)));
    run_phase(60, 85, 1'b1, 1'b0);

    set_timing(TICK_PERIOD_RST, BLINK_POINT_RST);
    run_phase(40, 90, 1'b1, 1'b0);

    set_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
    run_phase(20, 70, 1'b1, 1'b0);

    in_ch.valid <= 1'b0;
    wait_drained();

    $display("%0d samples over %0d timing settings, %0d displays checked, %0d bad",
             sb.samples, settings_used, sb.checked, sb.fails);
    $display("%0d countdowns ran out, %0d buzzer displays, %0d borrows from hours",
             sb.expiries, sb.buzzes, sb.hour_borrows);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
